@@ rtl/vwcp_pkg.sv @@
// Package for the variable-width code packer: widths, microcode types and control store.
package vwcp_pkg;

    // Field widths
    localparam int ACTION_BITS    = 1;
    localparam int WIDTH_BITS     = 5;
    localparam int VALUE_BITS     = 16;
    localparam int BYTE_BITS      = 8;
    localparam int ACC_BITS       = 23;
    localparam int COUNT_BITS     = 5;
    localparam int S_TDATA_BITS   = 24;

    // Widest code taken; wider requests saturate to it
    localparam int MAX_CODE_BITS  = 16;
    localparam int WIDEST_BITS    = (MAX_CODE_BITS > VALUE_BITS) ? VALUE_BITS : MAX_CODE_BITS;

    // Request kinds carried on the input tuser bit
    localparam logic ACTION_PUT   = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    // Microprogram steps
    typedef enum logic [1:0] {
        STEP_FETCH = 2'd0,
        STEP_EMIT  = 2'd1,
        STEP_FLUSH = 2'd2
    } step_t;

    // Branch conditions tested by the sequencer
    typedef enum logic [2:0] {
        COND_NEVER       = 3'd0,
        COND_NO_REQ      = 3'd1,
        COND_FLUSH_REQ   = 3'd2,
        COND_EMIT_AGAIN  = 3'd3,
        COND_FLUSH_STALL = 3'd4
    } cond_t;

    // Datapath control driven by one control word
    typedef struct packed {
        logic take_in;
        logic emit;
        logic flush;
    } ctrl_t;

    // Status flags the datapath returns to the sequencer
    typedef struct packed {
        logic no_req;
        logic flush_req;
        logic emit_again;
        logic flush_stall;
    } flags_t;

    // One control word: datapath controls, hold test, jump test and targets
    typedef struct packed {
        ctrl_t ctrl;
        cond_t hold_cond;
        cond_t jump_cond;
        step_t target;
        step_t next;
    } ucode_t;

    // Control store
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t word;
        begin
            word = '{ctrl: '0, hold_cond: COND_NEVER, jump_cond: COND_NEVER,
                     target: STEP_FETCH, next: STEP_FETCH};
            unique case (step)
                STEP_FETCH:
                begin
                    word.ctrl.take_in = 1'b1;
                    word.hold_cond    = COND_NO_REQ;
                    word.jump_cond    = COND_FLUSH_REQ;
                    word.target       = STEP_FLUSH;
                    word.next         = STEP_EMIT;
                end
                STEP_EMIT:
                begin
                    word.ctrl.emit    = 1'b1;
                    word.hold_cond    = COND_EMIT_AGAIN;
                    word.next         = STEP_FETCH;
                end
                STEP_FLUSH:
                begin
                    word.ctrl.flush   = 1'b1;
                    word.hold_cond    = COND_FLUSH_STALL;
                    word.next         = STEP_FETCH;
                end
                default:
                begin
                    word.next         = STEP_FETCH;
                end
            endcase
            return word;
        end
    endfunction

    // Evaluate a branch condition against the datapath flags
    function automatic logic cond_true(input cond_t cond, input flags_t flags);
        logic result;
        begin
            unique case (cond)
                COND_NEVER:       result = 1'b0;
                COND_NO_REQ:      result = flags.no_req;
                COND_FLUSH_REQ:   result = flags.flush_req;
                COND_EMIT_AGAIN:  result = flags.emit_again;
                COND_FLUSH_STALL: result = flags.flush_stall;
                default:          result = 1'b0;
            endcase
            return result;
        end
    endfunction

endpackage

@@ rtl/vwcp_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional branching.
module vwcp_seq
(
    input  logic            clk,
    input  logic            rst_n,
    input  vwcp_pkg::flags_t flags,
    output vwcp_pkg::ctrl_t  ctrl
);

    vwcp_pkg::step_t  step_reg;
    vwcp_pkg::step_t  step_next;
    vwcp_pkg::ucode_t word;
    logic             hold;
    logic             jump;

    // Decode the current control word and pick the next step
    always_comb
    begin
        word = vwcp_pkg::ucode_rom(step_reg);
        hold = vwcp_pkg::cond_true(word.hold_cond, flags);
        jump = vwcp_pkg::cond_true(word.jump_cond, flags);
        priority if (hold)
        begin
            step_next = step_reg;
        end
        else if (jump)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = word.next;
        end
    end

    assign ctrl = word.ctrl;

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= vwcp_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ rtl/variable_width_code_packer_unit.sv @@
// Variable-width code packer: MSB-first bit accumulator with a microcoded byte drain.
// A request is taken in the FETCH step; the EMIT step then registers its first byte on
// the output, and each further byte in a repeat of the EMIT step (each byte step waits
// while the output register is full and not being taken).
// A new request is not taken until the last one is drained, by the one-byte-per-step
// drain loop of the microprogram.
// Reset: rst_n clears the accumulator, the bit count, the step counter and output valid.
module variable_width_code_packer_unit
#(
    parameter int MAX_CODE_BITS = vwcp_pkg::MAX_CODE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [4:0] code_width, [20:5] code_value, [23:21] zero
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    localparam int AB = vwcp_pkg::ACC_BITS;
    localparam int CB = vwcp_pkg::COUNT_BITS;
    localparam int VB = vwcp_pkg::VALUE_BITS;
    localparam int WB = vwcp_pkg::WIDTH_BITS;
    localparam int BB = vwcp_pkg::BYTE_BITS;

    // Widest code taken, never more than the code value field
    localparam int WIDEST = (MAX_CODE_BITS > VB) ? VB : MAX_CODE_BITS;

    vwcp_pkg::ctrl_t  ctrl;
    vwcp_pkg::flags_t flags;

    logic [AB-1:0] acc_reg;
    logic [AB-1:0] acc_next;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [BB-1:0] out_byte_reg;
    logic [BB-1:0] out_byte_next;
    logic          out_last_reg;
    logic          out_last_next;

    logic [WB-1:0] req_width;
    logic [VB-1:0] req_value;
    logic [WB-1:0] put_width;
    logic [VB:0]   put_mask;
    logic [VB-1:0] put_value;
    logic          out_free;
    logic          byte_avail;
    logic [CB-1:0] count_rem;
    logic          emit_go;
    logic          emit_last;
    logic [2:0]    flush_shift;

    vwcp_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign s_tready = ctrl.take_in;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    // Unpack the request and saturate the width
    assign req_width = s_tdata[WB-1:0];
    assign req_value = s_tdata[WB+VB-1:WB];
    assign put_width = (req_width > WB'(WIDEST)) ? WB'(WIDEST) : req_width;
    assign put_mask  = ~({(VB+1){1'b1}} << put_width);
    assign put_value = req_value & put_mask[VB-1:0];

    // Drain status
    assign out_free    = !out_valid_reg || m_tready;
    assign byte_avail  = (count_reg >= CB'(BB));
    assign count_rem   = count_reg - CB'(BB);
    assign emit_go     = ctrl.emit && byte_avail && out_free;
    assign emit_last   = (count_rem < CB'(BB));
    assign flush_shift = 3'(BB - int'(count_reg));

    // Flags back to the sequencer
    always_comb
    begin
        flags.no_req      = !s_tvalid;
        flags.flush_req   = (s_tuser == vwcp_pkg::ACTION_FLUSH);
        flags.emit_again  = byte_avail && (!out_free || !emit_last);
        flags.flush_stall = (count_reg != '0) && !out_free;
    end

    // Datapath next state
    always_comb
    begin
        acc_next       = acc_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (ctrl.take_in && s_tvalid && (s_tuser == vwcp_pkg::ACTION_PUT))
        begin
            // Append the code below the pending bits
            acc_next   = AB'(acc_reg << put_width) | AB'(put_value);
            count_next = count_reg + CB'(put_width);
        end
        if (emit_go)
        begin
            // Take the oldest complete byte
            acc_next       = acc_reg;
            count_next     = count_rem;
            out_valid_next = 1'b1;
            out_byte_next  = BB'(acc_reg >> count_rem);
            out_last_next  = emit_last;
        end
        if (ctrl.flush && !flags.flush_stall)
        begin
            // Left-align the leftover bits, then clear
            if (count_reg != '0)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = acc_reg[BB-1:0] << flush_shift;
                out_last_next  = 1'b1;
            end
            acc_next   = '0;
            count_next = '0;
        end
    end

    // Hold accumulator, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // Pending bits never reach a full byte while waiting for a request
    a_fetch_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.take_in |-> (count_reg < CB'(BB)))
        else $error("byte left undrained at request fetch");

    // A taken request is worked off before the next one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one in progress");

    // A byte that is not the last of its request is followed by more drain work
    a_more_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && !emit_last) |=> (ctrl.emit && byte_avail))
        else $error("second byte of a request lost");

    // A completed flush step leaves no pending bits
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.flush && !flags.flush_stall) |=> (count_reg == '0) && (acc_reg == '0))
        else $error("flush left pending bits");

endmodule
